// ----- rtl/pee_pkg.sv -----
// shared constants, types and helpers for the postfix expression evaluator
`timescale 1ns / 1ps

package pee_pkg;

  localparam int StackDepth  = 64;
  localparam int ValueWidth  = 32;
  localparam int CharWidth   = 8;
  localparam int StatusWidth = 2;
  localparam int AddrWidth   = $clog2(StackDepth);
  localparam int CountWidth  = $clog2(StackDepth + 1);
  localparam int DivCntWidth = $clog2(ValueWidth);

  // ascii codes
  localparam logic [CharWidth-1:0] CharZero   = 8'h30;
  localparam logic [CharWidth-1:0] CharNine   = 8'h39;
  localparam logic [CharWidth-1:0] CharPlus   = 8'h2B;
  localparam logic [CharWidth-1:0] CharMinus  = 8'h2D;
  localparam logic [CharWidth-1:0] CharStar   = 8'h2A;
  localparam logic [CharWidth-1:0] CharSlash  = 8'h2F;
  localparam logic [CharWidth-1:0] CharRparen = 8'h29;

  // status codes
  localparam logic [StatusWidth-1:0] StatusOk        = 2'd0;
  localparam logic [StatusWidth-1:0] StatusUnderflow = 2'd1;
  localparam logic [StatusWidth-1:0] StatusOverflow  = 2'd2;
  localparam logic [StatusWidth-1:0] StatusDivZero   = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  function automatic op_e op_of_char(input logic [CharWidth-1:0] ch);
    op_e op;
    op = OP_ADD;
    case (ch)
      CharPlus:  op = OP_ADD;
      CharMinus: op = OP_SUB;
      CharStar:  op = OP_MUL;
      CharSlash: op = OP_DIV;
      default:   op = OP_ADD;
    endcase
    return op;
  endfunction

  // first error of an expression sticks
  function automatic logic [StatusWidth-1:0] flag_status(
    input logic [StatusWidth-1:0] cur,
    input logic [StatusWidth-1:0] code
  );
    return (cur == StatusOk) ? code : cur;
  endfunction

endpackage

// ----- rtl/postfix_expression_evaluator.sv -----
// postfix expression evaluator: operand stack in a synchronous memory, bit-serial divider
`timescale 1ns / 1ps

// Evaluates postfix expressions one character word at a time. A digit pushes
// its value, each of + - * / pops a then b and pushes b op a (wrapping at 32
// bits, division truncating toward zero), and ')' emits the popped value with
// the expression's sticky status (ok, underflow, overflow, divide by zero)
// before emptying the stack. Other characters are dropped. The operand stack
// is a 64-entry single-port-read memory with a registered read, so every pop
// is a separate memory read. A digit or an ignored character needs no extra
// state, + - * step through pop a, pop b, compute and push, ')' pops and then
// waits for the output register to drain, and / adds the divider steps (none
// when the divisor is zero) of the restoring divider that retires one quotient
// bit per cycle. The result is held in an output register, so new words are
// taken while it waits.
module postfix_expression_evaluator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic        [pee_pkg::CharWidth-1:0]  char_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pee_pkg::ValueWidth-1:0] result_value_o,
  output logic        [pee_pkg::StatusWidth-1:0] status_o
);

  import pee_pkg::*;

  // sequencer states
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPopB = 3'd1;
  localparam logic [2:0] SExec = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SDwb  = 3'd4;
  localparam logic [2:0] STerm = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CountWidth-1:0]  count_q, count_d;
  logic [StatusWidth-1:0] err_q, err_d;
  op_e                    op_q, op_d;
  logic                   pop_ok_q, pop_ok_d;   // last pop read a real entry
  logic [ValueWidth-1:0]  a_q, a_d;

  // divider registers
  logic [ValueWidth-1:0]  div_rem_q, div_rem_d;
  logic [ValueWidth-1:0]  div_quo_q, div_quo_d;
  logic [ValueWidth-1:0]  div_den_q, div_den_d;
  logic                   div_neg_q, div_neg_d;
  logic [DivCntWidth-1:0] div_cnt_q, div_cnt_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [ValueWidth-1:0]  out_value_q, out_value_d;
  logic [StatusWidth-1:0] out_status_q, out_status_d;

  // stack memory
  logic [ValueWidth-1:0]  stack_mem [StackDepth];
  logic [ValueWidth-1:0]  rdata_q;
  logic                   rd_en;
  logic [AddrWidth-1:0]   rd_addr;
  logic                   we;
  logic [AddrWidth-1:0]   wr_addr;
  logic [ValueWidth-1:0]  wr_data;

  logic [CountWidth-1:0]  count_dec;
  logic [ValueWidth-1:0]  b_val;
  logic [ValueWidth-1:0]  num_mag;
  logic [ValueWidth-1:0]  den_mag;
  logic [ValueWidth:0]    rem_shift;
  logic [ValueWidth:0]    rem_sub;
  logic                   rem_ge;
  logic                   out_load;

  assign count_dec = count_q - 1'b1;
  assign b_val     = pop_ok_q ? rdata_q : '0;
  assign num_mag   = b_val[ValueWidth-1] ? ('0 - b_val) : b_val;
  assign den_mag   = a_q[ValueWidth-1] ? ('0 - a_q) : a_q;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {div_rem_q, div_quo_q[ValueWidth-1]};
  assign rem_sub   = rem_shift - {1'b0, div_den_q};
  assign rem_ge    = (rem_shift >= {1'b0, div_den_q});

  assign out_load  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    err_d        = err_q;
    op_d         = op_q;
    pop_ok_d     = pop_ok_q;
    a_d          = a_q;
    div_rem_d    = div_rem_q;
    div_quo_d    = div_quo_q;
    div_den_d    = div_den_q;
    div_neg_d    = div_neg_q;
    div_cnt_d    = div_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    rd_en        = 1'b0;
    rd_addr      = count_dec[AddrWidth-1:0];
    we           = 1'b0;
    wr_addr      = count_q[AddrWidth-1:0];
    wr_data      = '0;

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          case (char_in_i) inside
            [CharZero:CharNine]: begin
              if (count_q == CountWidth'(StackDepth)) begin
                err_d = flag_status(err_q, StatusOverflow);
              end else begin
                we      = 1'b1;
                wr_data = ValueWidth'(char_in_i - CharZero);
                count_d = count_q + 1'b1;
              end
            end
            CharPlus, CharMinus, CharStar, CharSlash: begin
              op_d    = op_of_char(char_in_i);
              state_d = SPopB;
              if (count_q != '0) begin
                rd_en    = 1'b1;
                count_d  = count_dec;
                pop_ok_d = 1'b1;
              end else begin
                err_d    = flag_status(err_q, StatusUnderflow);
                pop_ok_d = 1'b0;
              end
            end
            CharRparen: begin
              state_d = STerm;
              if (count_q != '0) begin
                rd_en    = 1'b1;
                count_d  = count_dec;
                pop_ok_d = 1'b1;
              end else begin
                err_d    = flag_status(err_q, StatusUnderflow);
                pop_ok_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      SPopB: begin
        a_d     = pop_ok_q ? rdata_q : '0;
        state_d = SExec;
        if (count_q != '0) begin
          rd_en    = 1'b1;
          count_d  = count_dec;
          pop_ok_d = 1'b1;
        end else begin
          err_d    = flag_status(err_q, StatusUnderflow);
          pop_ok_d = 1'b0;
        end
      end

      SExec: begin
        // two pops just freed space, so the push always fits
        we      = 1'b1;
        count_d = count_q + 1'b1;
        state_d = SIdle;
        case (op_q)
          OP_ADD: wr_data = b_val + a_q;
          OP_SUB: wr_data = b_val - a_q;
          OP_MUL: wr_data = b_val * a_q;
          OP_DIV: begin
            if (den_mag == '0) begin
              err_d   = flag_status(err_q, StatusDivZero);
              wr_data = '0;
            end else begin
              we        = 1'b0;
              count_d   = count_q;
              state_d   = SDiv;
              div_rem_d = '0;
              div_quo_d = num_mag;
              div_den_d = den_mag;
              div_neg_d = a_q[ValueWidth-1] ^ b_val[ValueWidth-1];
              div_cnt_d = DivCntWidth'(ValueWidth - 1);
            end
          end
          default: wr_data = '0;
        endcase
      end

      SDiv: begin
        div_rem_d = rem_ge ? rem_sub[ValueWidth-1:0] : rem_shift[ValueWidth-1:0];
        div_quo_d = {div_quo_q[ValueWidth-2:0], rem_ge};
        if (div_cnt_q == '0) begin
          state_d = SDwb;
        end else begin
          div_cnt_d = div_cnt_q - 1'b1;
        end
      end

      SDwb: begin
        we      = 1'b1;
        wr_data = div_neg_q ? ('0 - div_quo_q) : div_quo_q;
        count_d = count_q + 1'b1;
        state_d = SIdle;
      end

      STerm: begin
        // popped value sits in rdata_q until the output register frees up
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_value_d  = b_val;
          out_status_d = err_q;
          count_d      = '0;
          err_d        = StatusOk;
          state_d      = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  // reads and writes never hit the stack in the same cycle, the sequencer
  // never asserts the read and the write enable together
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      err_q       <= StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pop_ok_q     <= pop_ok_d;
    a_q          <= a_d;
    div_rem_q    <= div_rem_d;
    div_quo_q    <= div_quo_d;
    div_den_q    <= div_den_d;
    div_neg_q    <= div_neg_d;
    div_cnt_q    <= div_cnt_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o     = (state_q != SIdle);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

  // stack fill never runs past the memory
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountWidth'(StackDepth))
    else $error("stack count beyond depth");

  // a terminator word always leads to the emit state
  a_term_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && char_in_i == CharRparen) |=> state_q == STerm)
    else $error("terminator not followed by emit");

  // emitting a result clears the stack and the sticky status
  a_term_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == STerm && out_load) |=> (count_q == '0 && err_q == StatusOk && out_valid_q))
    else $error("expression state not cleared after emit");

  // divider counts down one bit per cycle without leaving the loop
  a_div_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDiv && div_cnt_q != '0) |=>
      (state_q == SDiv && div_cnt_q == DivCntWidth'($past(div_cnt_q) - 1'b1)))
    else $error("divider step sequence broken");

endmodule

// ----- bench/postfix_result_checker.sv -----
// result checker for the postfix evaluator: predicts results from accepted words and compares
`timescale 1ns / 1ps

module postfix_result_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic        [pee_pkg::CharWidth-1:0]   char_in_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [pee_pkg::ValueWidth-1:0]  result_value_i,
  input  logic        [pee_pkg::StatusWidth-1:0] status_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  import pee_pkg::*;

  localparam int MaxReports = 10;

  typedef struct packed {
    logic signed [ValueWidth-1:0]  value;
    logic        [StatusWidth-1:0] status;
  } eval_result_t;

  eval_result_t           expected_results_q[$];
  logic [ValueWidth-1:0]  operand_stack [StackDepth];
  int unsigned            operand_count = 0;
  logic [StatusWidth-1:0] sticky_status = StatusOk;

  initial fail_count_o = 0;
  initial pending_o    = 0;

  function automatic void log_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= MaxReports) $display("result check: %s", msg);
  endfunction

  // first error of an expression wins
  function automatic void raise_status(input logic [StatusWidth-1:0] code);
    if (sticky_status == StatusOk) sticky_status = code;
  endfunction

  function automatic logic [ValueWidth-1:0] pop_operand();
    if (operand_count == 0) begin
      raise_status(StatusUnderflow);
      return '0;
    end
    operand_count--;
    return operand_stack[operand_count];
  endfunction

  function automatic void push_operand(input logic [ValueWidth-1:0] v);
    if (operand_count >= StackDepth) begin
      raise_status(StatusOverflow);
    end else begin
      operand_stack[operand_count] = v;
      operand_count++;
    end
  endfunction

  // truncates toward zero; most negative over minus one wraps back to itself
  function automatic logic [ValueWidth-1:0] signed_quotient(
    input logic [ValueWidth-1:0] num,
    input logic [ValueWidth-1:0] den
  );
    logic [ValueWidth-1:0] num_mag;
    logic [ValueWidth-1:0] den_mag;
    logic [ValueWidth-1:0] quo;
    num_mag = num[ValueWidth-1] ? -num : num;
    den_mag = den[ValueWidth-1] ? -den : den;
    if (den_mag == '0) begin
      raise_status(StatusDivZero);
      return '0;
    end
    quo = num_mag / den_mag;
    return (num[ValueWidth-1] != den[ValueWidth-1]) ? -quo : quo;
  endfunction

  function automatic bit decode_op(input logic [CharWidth-1:0] ch, output op_e op);
    op = OP_ADD;
    case (ch)
      CharPlus:  op = OP_ADD;
      CharMinus: op = OP_SUB;
      CharStar:  op = OP_MUL;
      CharSlash: op = OP_DIV;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void evaluate_char(input logic [CharWidth-1:0] ch);
    op_e                   op;
    logic [ValueWidth-1:0] a;
    logic [ValueWidth-1:0] b;
    logic [ValueWidth-1:0] r;
    eval_result_t          res;
    if (ch >= CharZero && ch <= CharNine) begin
      push_operand(ValueWidth'(ch - CharZero));
    end else if (decode_op(ch, op)) begin
      a = pop_operand();
      b = pop_operand();
      case (op)
        OP_ADD:  r = b + a;
        OP_SUB:  r = b - a;
        OP_MUL:  r = b * a;
        default: r = signed_quotient(b, a);
      endcase
      push_operand(r);
    end else if (ch == CharRparen) begin
      res.value  = pop_operand();
      res.status = sticky_status;
      expected_results_q.push_back(res);
      operand_count = 0;
      sticky_status = StatusOk;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    eval_result_t want;
    if (!rst_ni) begin
      expected_results_q.delete();
      operand_count = 0;
      sticky_status = StatusOk;
    end else begin
      if (in_valid_i && !in_stall_i) evaluate_char(char_in_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          log_failure($sformatf("unexpected result value %0d status %0d",
                                result_value_i, status_i));
        end else begin
          want = expected_results_q.pop_front();
          if (result_value_i !== want.value)
            log_failure($sformatf("value: expected %0d, got %0d",
                                  want.value, result_value_i));
          if (status_i !== want.status)
            log_failure($sformatf("status: expected %0d, got %0d",
                                  want.status, status_i));
        end
      end
    end
    pending_o = expected_results_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// testbench top for the postfix evaluator: word stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_top;

  import pee_pkg::*;

  // long receiver hold-off, comfortably above the time a divide takes
  localparam int HoldCycles    = 400;
  // settling time after the last expected result (divide is the slowest word)
  localparam int DrainCycles   = 40;
  // cycles without any accepted word before the run is declared hung
  localparam int WatchdogLimit = 4000;
  // meaningful words per random phase
  localparam int PhaseItems    = 400;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic [CharWidth-1:0]   char_in_i   = '0;
  logic                   out_stall_i = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic signed [ValueWidth-1:0] result_value_o;
  logic [StatusWidth-1:0] status_o;

  int fail_count;
  int pending_results;

  // flow-control knobs, percentages per cycle
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // hold-off request from the stimulus, served by the stall process
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;

  int words_sent  = 0;
  int idle_cycles = 0;

  logic [CharWidth-1:0] expr_text_q[$];

  always #1 clk_i = ~clk_i;

  postfix_expression_evaluator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  postfix_result_checker u_result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .char_in_i      (char_in_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_i (result_value_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_results)
  );

  // receiver side: random stall, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req != hold_ack) begin
      hold_ack    = hold_req;
      hold_left   = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // hang detection: any accepted word on either side restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // offer one word from a falling edge and hold it until it is taken
  task automatic send_word(input logic [CharWidth-1:0] ch);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // ignored characters do not count towards the phase length
    if ((ch >= CharZero && ch <= CharNine) || ch == CharPlus || ch == CharMinus ||
        ch == CharStar || ch == CharSlash || ch == CharRparen)
      words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  // drop valid, wait for every outstanding result, then let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [CharWidth-1:0] rand_digit();
    return CharZero + CharWidth'($urandom_range(9));
  endfunction

  function automatic logic [CharWidth-1:0] rand_op();
    case ($urandom_range(3))
      0:       return CharPlus;
      1:       return CharMinus;
      2:       return CharStar;
      default: return CharSlash;
    endcase
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_text_q.push_back(s[i]);
  endfunction

  // one random expression; mostly well formed so the arithmetic gets exercised
  task automatic send_expression();
    int kind;
    int depth;
    int pushes_left;
    kind = $urandom_range(99);
    expr_text_q.delete();
    if (kind < 4) begin
      // run the stack close to its top and often past it, then fold a little
      repeat ($urandom_range(StackDepth + 6, StackDepth - 2))
        expr_text_q.push_back(rand_digit());
      repeat ($urandom_range(3)) expr_text_q.push_back(rand_op());
    end else if (kind < 7) begin
      // build the most negative value by doubling, then divide it by minus one
      add_text("02-");
      repeat (ValueWidth - 2) add_text("2*");
      add_text("01-/");
      if ($urandom_range(1)) add_text("2*");
    end else if (kind < 13) begin
      // long product chain, wraps past 32 bits
      expr_text_q.push_back(CharZero + CharWidth'($urandom_range(9, 2)));
      repeat ($urandom_range(14, 6)) begin
        expr_text_q.push_back(rand_digit());
        expr_text_q.push_back(($urandom_range(3) == 0) ? rand_op() : CharStar);
      end
    end else if (kind < 82) begin
      // well formed, with the odd stray byte mixed in
      pushes_left = $urandom_range(10, 1);
      depth = 0;
      while (pushes_left > 0 || depth > 1) begin
        if ($urandom_range(99) < 8) expr_text_q.push_back(CharWidth'($urandom_range(255)));
        if (depth < 2 || (pushes_left > 0 && $urandom_range(1) == 0)) begin
          expr_text_q.push_back(rand_digit());
          pushes_left--;
          depth++;
        end else begin
          expr_text_q.push_back(rand_op());
          depth--;
        end
      end
    end else begin
      // broken sequence, terminator may come anywhere
      repeat ($urandom_range(8, 1)) begin
        case ($urandom_range(3))
          0:       expr_text_q.push_back(rand_digit());
          1:       expr_text_q.push_back(rand_op());
          2:       expr_text_q.push_back(CharRparen);
          default: expr_text_q.push_back(CharWidth'($urandom_range(255)));
        endcase
      end
    end
    expr_text_q.push_back(CharRparen);
    foreach (expr_text_q[i]) send_word(expr_text_q[i]);
  endtask

  initial begin
    int target;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words: every operator, truncation of a negative quotient,
    // sticky status (underflow hides a later divide by zero), divide by
    // zero alone, terminator on an empty stack, ignored extreme bytes
    send_text("93-4*)");
    send_text("07-2/)");
    send_text("+50/)");
    send_text("50/8+)");
    send_word(8'h00);
    send_word(8'hFF);
    send_text(")");
    drain_results();

    // receiver holds off while words keep coming, so the result register
    // fills and the input side has to stall
    hold_req++;
    repeat (12) send_text("12+)");
    drain_results();

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 74; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      target = words_sent + PhaseItems;
      while (words_sent < target) send_expression();
      drain_results();
    end

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
